### design/odo_pkg.sv
// Shared types, constants and tables for the differential drive odometry core.
package odo_pkg;

   localparam int DIV_W  = 70;   // divider dividend / quotient width
   localparam int DVS_W  = 26;   // divider divisor width
   localparam int STEP_W = 7;    // loop counter width

   localparam logic [31:0] TWO_PI_Q29     = 32'd3373259426;
   localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

   localparam logic [2:0] CSR_COUNTS_PER_REV = 3'd0;
   localparam logic [2:0] CSR_GEAR_RATIO     = 3'd1;
   localparam logic [2:0] CSR_LEFT_RADIUS    = 3'd2;
   localparam logic [2:0] CSR_RIGHT_RADIUS   = 3'd3;
   localparam logic [2:0] CSR_TRACK          = 3'd4;

   localparam logic [15:0] RST_COUNTS_PER_REV = 16'd2000;
   localparam logic [15:0] RST_GEAR_RATIO     = 16'd2979;
   localparam logic [17:0] RST_RADIUS         = 18'd13107;
   localparam logic [17:0] RST_TRACK          = 18'd44112;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_LOAD,
      OP_BAD,
      OP_W_MUL1,
      OP_W_MUL2,
      OP_DIV_LOAD_W,
      OP_DIV_STEP,
      OP_W_LO,
      OP_W_HI,
      OP_W_FIN,
      OP_MEAN,
      OP_N_MUL,
      OP_DIV_LOAD_T,
      OP_ANGLE,
      OP_COR_STEP
   } op_type;

   typedef enum logic [2:0] {
      OPX_NONE,
      OPX_MOVE_MUL,
      OPX_MOVE_ADD,
      OPX_PUBLISH
   } opx_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_W_MUL1,
      ST_W_MUL2,
      ST_W_DIVI,
      ST_W_DIV,
      ST_W_LO,
      ST_W_HI,
      ST_W_FIN,
      ST_MEAN,
      ST_N_MUL,
      ST_T_DIVI,
      ST_T_DIV,
      ST_ANGLE,
      ST_COR,
      ST_MOVE_MUL,
      ST_MOVE_ADD,
      ST_PUBLISH
   } state_type;

   typedef struct packed {
      op_type              op;
      opx_type             opx;
      logic                wheel;   // 0 left, 1 right
      logic [STEP_W-1:0]   step;
   } cmd_type;

   typedef struct packed {
      logic is_load;
      logic zero_interval;
   } status_type;

   // arctan(2^-i) in binary angle units, 2^32 per turn
   function automatic logic [31:0] atan_bam(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         5'd24: v = 32'h00000029;
         5'd25: v = 32'h00000014;
         5'd26: v = 32'h0000000A;
         5'd27: v = 32'h00000005;
         5'd28: v = 32'h00000003;
         5'd29: v = 32'h00000001;
         5'd30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

### design/odo_ctrl.sv
// Sequencing state machine for the odometry core.
module odo_ctrl #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  odo_pkg::status_type  status,
   output odo_pkg::cmd_type     cmd
);
   import odo_pkg::*;

   localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_W - 1);
   localparam logic [STEP_W-1:0] COR_LAST = STEP_W'(CORDIC_STEPS - 1);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              wheel_ff, wheel_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         wheel_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         wheel_ff     <= wheel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      wheel_in     = wheel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = OP_NONE;
      cmd.opx      = OPX_NONE;
      cmd.wheel    = wheel_ff;
      cmd.step     = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_CAPTURE;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_load) begin
               cmd.op   = OP_LOAD;
               state_in = ST_PUBLISH;
            end else if (status.zero_interval) begin
               cmd.op   = OP_BAD;
               state_in = ST_PUBLISH;
            end else begin
               wheel_in = 1'b0;
               state_in = ST_W_MUL1;
            end
         end
         ST_W_MUL1: begin
            cmd.op   = OP_W_MUL1;
            state_in = ST_W_MUL2;
         end
         ST_W_MUL2: begin
            cmd.op   = OP_W_MUL2;
            state_in = ST_W_DIVI;
         end
         ST_W_DIVI: begin
            cmd.op   = OP_DIV_LOAD_W;
            step_in  = '0;
            state_in = ST_W_DIV;
         end
         ST_W_DIV: begin
            cmd.op  = OP_DIV_STEP;
            step_in = step_ff + 1'b1;
            if (step_ff == DIV_LAST) begin
               state_in = ST_W_LO;
            end
         end
         ST_W_LO: begin
            cmd.op   = OP_W_LO;
            state_in = ST_W_HI;
         end
         ST_W_HI: begin
            cmd.op   = OP_W_HI;
            state_in = ST_W_FIN;
         end
         ST_W_FIN: begin
            cmd.op = OP_W_FIN;
            if (wheel_ff) begin
               state_in = ST_MEAN;
            end else begin
               wheel_in = 1'b1;
               state_in = ST_W_MUL1;
            end
         end
         ST_MEAN: begin
            cmd.op   = OP_MEAN;
            state_in = ST_N_MUL;
         end
         ST_N_MUL: begin
            cmd.op   = OP_N_MUL;
            state_in = ST_T_DIVI;
         end
         ST_T_DIVI: begin
            cmd.op   = OP_DIV_LOAD_T;
            step_in  = '0;
            state_in = ST_T_DIV;
         end
         ST_T_DIV: begin
            cmd.op  = OP_DIV_STEP;
            step_in = step_ff + 1'b1;
            if (step_ff == DIV_LAST) begin
               state_in = ST_ANGLE;
            end
         end
         ST_ANGLE: begin
            cmd.op   = OP_ANGLE;
            step_in  = '0;
            state_in = ST_COR;
         end
         ST_COR: begin
            cmd.op  = OP_COR_STEP;
            step_in = step_ff + 1'b1;
            if (step_ff == COR_LAST) begin
               state_in = ST_MOVE_MUL;
            end
         end
         ST_MOVE_MUL: begin
            cmd.opx  = OPX_MOVE_MUL;
            state_in = ST_MOVE_ADD;
         end
         ST_MOVE_ADD: begin
            cmd.opx  = OPX_MOVE_ADD;
            state_in = ST_PUBLISH;
         end
         ST_PUBLISH: begin
            // wait until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.opx      = OPX_PUBLISH;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### design/odo_datapath.sv
// Datapath for the odometry core: item latch, registers, divider, CORDIC, pose.
module odo_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  odo_pkg::cmd_type     cmd,
   output odo_pkg::status_type  status,
   input  logic                 csr_wr_en,
   input  logic [2:0]           csr_index,
   input  logic [17:0]          csr_wdata,
   input  logic                 req_kind,
   input  logic signed [23:0]   req_left_count,
   input  logic signed [23:0]   req_right_count,
   input  logic [23:0]          req_interval_us,
   input  logic signed [31:0]   req_load_x,
   input  logic signed [31:0]   req_load_y,
   input  logic signed [31:0]   req_load_heading,
   output logic signed [31:0]   rsp_pos_x,
   output logic signed [31:0]   rsp_pos_y,
   output logic signed [31:0]   rsp_heading,
   output logic                 rsp_bad_interval
);
   import odo_pkg::*;

   localparam int SH_UP = (FRAC_BITS <= 16) ? (16 - FRAC_BITS) : 0;
   localparam int SH_DN = (FRAC_BITS > 16) ? (FRAC_BITS - 16) : 0;
   localparam int D_SH  = 29 - FRAC_BITS;

   // configuration
   logic [15:0] cpr_ff, ratio_ff;
   logic [17:0] lrad_ff, rrad_ff, track_ff;

   // latched item
   logic               kind_ff, zero_int_ff;
   logic signed [23:0] left_ff, right_ff;
   logic [31:0]        lx_ff, ly_ff, lh_ff;

   // pose
   logic [31:0] x_ff, y_ff, head_ff;
   logic        bad_ff;

   // wheel distance
   logic [56:0]        prod_ff;
   logic [63:0]        lo_ff;
   logic [57:0]        mid_ff;
   logic signed [31:0] dl_ff, dr_ff;

   // heading change
   logic signed [31:0] mean_ff;
   logic [31:0]        absd_ff;
   logic               neg_ff;
   logic [61:0]        n_ff;
   logic [31:0]        dth_ff;

   // divider
   logic [DIV_W-1:0] quo_ff;
   logic [DVS_W-1:0] rem_ff, dvs_ff;

   // CORDIC
   logic signed [33:0] cx_ff, cy_ff, cz_ff;
   logic               flip_ff;

   // move
   logic signed [65:0] px_ff, py_ff;

   // output register
   logic [31:0] out_x_ff, out_y_ff, out_h_ff;
   logic        out_bad_ff;

   function automatic logic [31:0] sat_add(input logic [31:0] base,
                                           input logic signed [35:0] dv);
      logic signed [36:0] s;
      s = 37'(signed'(base)) + 37'(dv);
      if (s > 37'sd2147483647) begin
         return 32'h7FFFFFFF;
      end else if (s < -37'sd2147483648) begin
         return 32'h80000000;
      end
      return s[31:0];
   endfunction

   // combinational helpers
   logic signed [23:0] cnt_sel;
   logic [23:0]        mag;
   logic [17:0]        rad_sel;
   logic [15:0]        ppr;
   logic [17:0]        trk;
   logic [DVS_W:0]     rem_sh;
   logic               div_ge;
   logic [DVS_W:0]     rem_sub;
   logic [57:0]        dsh;
   logic [30:0]        dmag;
   logic signed [31:0] dval;
   logic signed [32:0] dsum, ddiff;
   logic [31:0]        dth_in, hth_in, angle;
   logic               fold;
   logic [31:0]        z0;
   logic [4:0]         cidx;
   logic signed [33:0] xs, ys, at;
   logic signed [33:0] cosv, sinv;

   always_comb begin
      cnt_sel = cmd.wheel ? right_ff : left_ff;
      mag     = cnt_sel[23] ? 24'(-cnt_sel) : 24'(cnt_sel);
      rad_sel = cmd.wheel ? rrad_ff : lrad_ff;
      ppr     = (cpr_ff == '0) ? 16'd1 : cpr_ff;
      trk     = (track_ff == '0) ? 18'd1 : track_ff;

      rem_sh  = {rem_ff, quo_ff[DIV_W-1]};
      div_ge  = (rem_sh >= {1'b0, dvs_ff});
      rem_sub = rem_sh - {1'b0, dvs_ff};

      dsh  = mid_ff >> D_SH;
      dmag = (dsh > 58'h7FFFFFFF) ? 31'h7FFFFFFF : dsh[30:0];
      dval = cnt_sel[23] ? -signed'({1'b0, dmag}) : signed'({1'b0, dmag});

      dsum  = 33'(dl_ff) + 33'(dr_ff);
      ddiff = 33'(dr_ff) - 33'(dl_ff);

      dth_in = neg_ff ? (32'd0 - quo_ff[31:0]) : quo_ff[31:0];
      hth_in = neg_ff ? (32'd0 - quo_ff[32:1]) : quo_ff[32:1];
      angle  = head_ff + hth_in;
      // fold into the right half plane, undo by negation at the end
      fold   = (signed'(angle) > 32'sh40000000) || (signed'(angle) < -32'sh40000000);
      z0     = fold ? {~angle[31], angle[30:0]} : angle;

      cidx = cmd.step[4:0];
      xs   = cx_ff >>> cidx;
      ys   = cy_ff >>> cidx;
      at   = signed'({2'b00, atan_bam(cidx)});

      cosv = flip_ff ? -cx_ff : cx_ff;
      sinv = flip_ff ? -cy_ff : cy_ff;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cpr_ff   <= RST_COUNTS_PER_REV;
         ratio_ff <= RST_GEAR_RATIO;
         lrad_ff  <= RST_RADIUS;
         rrad_ff  <= RST_RADIUS;
         track_ff <= RST_TRACK;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_COUNTS_PER_REV: cpr_ff   <= csr_wdata[15:0];
            CSR_GEAR_RATIO:     ratio_ff <= csr_wdata[15:0];
            CSR_LEFT_RADIUS:    lrad_ff  <= csr_wdata;
            CSR_RIGHT_RADIUS:   rrad_ff  <= csr_wdata;
            CSR_TRACK:          track_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pose state
   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff    <= '0;
         y_ff    <= '0;
         head_ff <= '0;
         bad_ff  <= 1'b0;
      end else begin
         if (cmd.op == OP_LOAD) begin
            x_ff    <= lx_ff;
            y_ff    <= ly_ff;
            head_ff <= lh_ff;
            bad_ff  <= 1'b0;
         end else if (cmd.op == OP_BAD) begin
            bad_ff <= 1'b1;
         end else if (cmd.opx == OPX_MOVE_ADD) begin
            x_ff    <= sat_add(x_ff, px_ff[65:30]);
            y_ff    <= sat_add(y_ff, py_ff[65:30]);
            head_ff <= head_ff + dth_ff;
            bad_ff  <= 1'b0;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_CAPTURE: begin
            kind_ff     <= req_kind;
            zero_int_ff <= (req_interval_us == '0);
            left_ff     <= req_left_count;
            right_ff    <= req_right_count;
            lx_ff       <= req_load_x;
            ly_ff       <= req_load_y;
            lh_ff       <= req_load_heading;
         end
         OP_W_MUL1: prod_ff <= 57'(mag * ratio_ff);
         OP_W_MUL2: prod_ff <= 57'(prod_ff[39:0] * rad_sel);
         OP_DIV_LOAD_W: begin
            quo_ff <= DIV_W'(prod_ff);
            rem_ff <= '0;
            dvs_ff <= DVS_W'(ppr);
         end
         OP_DIV_STEP: begin
            rem_ff <= div_ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], div_ge};
         end
         OP_W_LO: lo_ff <= 64'(quo_ff[31:0] * TWO_PI_Q29);
         OP_W_HI: mid_ff <= 58'(quo_ff[56:32] * TWO_PI_Q29) + 58'(lo_ff[63:32]);
         OP_W_FIN: begin
            if (cmd.wheel) begin
               dr_ff <= dval;
            end else begin
               dl_ff <= dval;
            end
         end
         OP_MEAN: begin
            // halve, rounding toward zero
            mean_ff <= 32'((dsum + 33'(dsum[32])) >>> 1);
            absd_ff <= ddiff[32] ? 32'(-ddiff) : ddiff[31:0];
            neg_ff  <= ddiff[32];
         end
         OP_N_MUL: n_ff <= 62'(absd_ff * INV_TWO_PI_Q32);
         OP_DIV_LOAD_T: begin
            quo_ff <= DIV_W'(n_ff) << SH_UP;
            rem_ff <= '0;
            dvs_ff <= DVS_W'(trk) << SH_DN;
         end
         OP_ANGLE: begin
            dth_ff  <= dth_in;
            flip_ff <= fold;
            cx_ff   <= CORDIC_GAIN_Q30;
            cy_ff   <= '0;
            cz_ff   <= 34'(signed'(z0));
         end
         OP_COR_STEP: begin
            if (!cz_ff[33]) begin
               cx_ff <= cx_ff - ys;
               cy_ff <= cy_ff + xs;
               cz_ff <= cz_ff - at;
            end else begin
               cx_ff <= cx_ff + ys;
               cy_ff <= cy_ff - xs;
               cz_ff <= cz_ff + at;
            end
         end
         default: ;
      endcase
   end

   // move products and output register
   always_ff @(posedge clock) begin
      unique case (cmd.opx)
         OPX_MOVE_MUL: begin
            px_ff <= mean_ff * cosv;
            py_ff <= mean_ff * sinv;
         end
         OPX_PUBLISH: begin
            out_x_ff   <= x_ff;
            out_y_ff   <= y_ff;
            out_h_ff   <= head_ff;
            out_bad_ff <= bad_ff;
         end
         default: ;
      endcase
   end

   assign status.is_load       = kind_ff;
   assign status.zero_interval = zero_int_ff;

   assign rsp_pos_x        = signed'(out_x_ff);
   assign rsp_pos_y        = signed'(out_y_ff);
   assign rsp_heading      = signed'(out_h_ff);
   assign rsp_bad_interval = out_bad_ff;

endmodule

### design/differential_drive_odometry_core.sv
// Top level of the differential drive odometry core.
//
// Input channel (req_*): one item per update or pose load, valid/ready.
// req_kind 0 is an encoder update, 1 loads x, y and heading directly.
// Result channel (rsp_*): one item per input item with the pose after the
// step and the bad interval flag, valid/ready.
// Configuration (csr_*): write enable, register index and data; writes
// take effect at once and must be made while the block is idle; the
// block itself does not enforce this. An update runs two bit-serial
// divides for the wheel distances, one for the heading change, and one
// CORDIC iteration per cycle. A load or an update with zero interval goes
// from decode straight to publish. One item is worked on at a time; the
// next is accepted once the current result sits in the output register.
// If the receiver stalls, the result holds in the output register and the
// next item's result waits in the final state until the register frees.
// Reset clears the pose to zero, loads the default geometry registers and
// empties the output register.
module differential_drive_odometry_core #(
   parameter int CORDIC_STEPS = 24,
   parameter int FRAC_BITS    = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic signed [23:0] req_left_count,
   input  logic signed [23:0] req_right_count,
   input  logic [23:0]        req_interval_us,
   input  logic signed [31:0] req_load_x,
   input  logic signed [31:0] req_load_y,
   input  logic signed [31:0] req_load_heading,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_heading,
   output logic               rsp_bad_interval,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [17:0]        csr_wdata
);
   import odo_pkg::*;

   cmd_type    cmd;
   status_type status;

   odo_ctrl #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   odo_datapath #(
      .FRAC_BITS(FRAC_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_kind         (req_kind),
      .req_left_count   (req_left_count),
      .req_right_count  (req_right_count),
      .req_interval_us  (req_interval_us),
      .req_load_x       (req_load_x),
      .req_load_y       (req_load_y),
      .req_load_heading (req_load_heading),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_heading      (rsp_heading),
      .rsp_bad_interval (rsp_bad_interval)
   );

endmodule

### test/tb_differential_drive_odometry_core.sv
// Self-checking testbench for the differential drive odometry core.
typedef struct {
   logic [31:0] x;
   logic [31:0] y;
   logic [31:0] hdg;
   logic        bad;
} pose_item_type;

class odometry_scoreboard;
   localparam int STEPS = 24;
   localparam int FRAC  = 16;

   logic [15:0] cpr, gear;
   logic [17:0] rad_l, rad_r, track;
   logic [31:0] px, py, ph;
   pose_item_type pending_poses[$];
   int          mismatches;
   int          checked;
   int          n_updates, n_loads, n_bad;

   function void reset_state();
      cpr = odo_pkg::RST_COUNTS_PER_REV;
      gear = odo_pkg::RST_GEAR_RATIO;
      rad_l = odo_pkg::RST_RADIUS;
      rad_r = odo_pkg::RST_RADIUS;
      track = odo_pkg::RST_TRACK;
      px = 0;
      py = 0;
      ph = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [17:0] d);
      case (idx)
         odo_pkg::CSR_COUNTS_PER_REV: cpr = d[15:0];
         odo_pkg::CSR_GEAR_RATIO:     gear = d[15:0];
         odo_pkg::CSR_LEFT_RADIUS:    rad_l = d;
         odo_pkg::CSR_RIGHT_RADIUS:   rad_r = d;
         odo_pkg::CSR_TRACK:          track = d;
         default: ;
      endcase
   endfunction

   function longint wheel_distance(logic signed [23:0] cnt, logic [17:0] radius);
      logic [63:0] mag, ppr, c, hi, lo, mid, d;
      mag = 64'(cnt < 0 ? -longint'(cnt) : longint'(cnt));
      ppr = (cpr == 0) ? 64'd1 : 64'(cpr);
      c = mag * 64'(gear) * 64'(radius) / ppr;
      hi = (c >> 32) * 64'(odo_pkg::TWO_PI_Q29);
      lo = {32'd0, c[31:0]} * 64'(odo_pkg::TWO_PI_Q29);
      mid = hi + (lo >> 32);
      d = mid >> (29 - FRAC);
      if (d > 64'h7FFF_FFFF) d = 64'h7FFF_FFFF;
      return (cnt < 0) ? -longint'(d) : longint'(d);
   endfunction

   function void sin_cos(logic [31:0] ang, output longint cs, output longint sn);
      longint a, x, y, z, xs, ys;
      logic flip;
      a = longint'($signed(ang));
      flip = 0;
      if (a > (64'sd1 <<< 30) || a < -(64'sd1 <<< 30)) begin
         ang = ang + 32'h8000_0000;
         flip = 1;
      end
      z = longint'($signed(ang));
      x = longint'(odo_pkg::CORDIC_GAIN_Q30);
      y = 0;
      for (int i = 0; i < STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys;
            y += xs;
            z -= longint'(odo_pkg::atan_bam(i[4:0]));
         end else begin
            x += ys;
            y -= xs;
            z += longint'(odo_pkg::atan_bam(i[4:0]));
         end
      end
      cs = flip ? -x : x;
      sn = flip ? -y : y;
   endfunction

   function logic [31:0] clamp_add(logic [31:0] base, longint delta);
      longint v;
      v = longint'($signed(base)) + delta;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   // accepted input item -> expected pose
   function void note_input(logic kind, logic signed [23:0] lc, logic signed [23:0] rc,
                            logic [23:0] iv, logic [31:0] lx, logic [31:0] ly,
                            logic [31:0] lh);
      pose_item_type e;
      longint dl, dr, mean, diff, cs, sn;
      logic [63:0] n, t, m;
      logic [31:0] dth, hth;
      e.bad = 0;
      if (kind) begin
         px = lx;
         py = ly;
         ph = lh;
         n_loads++;
      end else if (iv == 0) begin
         e.bad = 1;
         n_bad++;
      end else begin
         dl = wheel_distance(lc, rad_l);
         dr = wheel_distance(rc, rad_r);
         mean = (dl + dr) / 2;
         diff = dr - dl;
         t = (track == 0) ? 64'd1 : 64'(track);
         n = 64'(diff < 0 ? -diff : diff) * 64'(odo_pkg::INV_TWO_PI_Q32);
         m = n / t;
         dth = m[31:0];
         hth = m[32:1];
         if (diff < 0) begin
            dth = -dth;
            hth = -hth;
         end
         sin_cos(ph + hth, cs, sn);
         px = clamp_add(px, (mean * cs) >>> 30);
         py = clamp_add(py, (mean * sn) >>> 30);
         ph = ph + dth;
         n_updates++;
      end
      e.x = px;
      e.y = py;
      e.hdg = ph;
      pending_poses.push_back(e);
   endfunction

   function void check_result(pose_item_type got);
      pose_item_type e;
      checked++;
      if (pending_poses.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("result with no pending item: x=%h y=%h h=%h b=%b",
                                        got.x, got.y, got.hdg, got.bad);
         return;
      end
      e = pending_poses.pop_front();
      if (e.x !== got.x || e.y !== got.y || e.hdg !== got.hdg || e.bad !== got.bad) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch #%0d: exp x=%h y=%h h=%h b=%b got x=%h y=%h h=%h b=%b",
                     checked, e.x, e.y, e.hdg, e.bad, got.x, got.y, got.hdg, got.bad);
      end
   endfunction
endclass

module tb_differential_drive_odometry_core;
   import odo_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int DRAIN_CYCLES = 300;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic               req_kind = 0;
   logic signed [23:0] req_left_count = 0;
   logic signed [23:0] req_right_count = 0;
   logic [23:0]        req_interval_us = 0;
   logic signed [31:0] req_load_x = 0;
   logic signed [31:0] req_load_y = 0;
   logic signed [31:0] req_load_heading = 0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic signed [31:0] rsp_pos_x;
   logic signed [31:0] rsp_pos_y;
   logic signed [31:0] rsp_heading;
   logic               rsp_bad_interval;
   logic               csr_wr_en = 0;
   logic [2:0]         csr_index = 0;
   logic [17:0]        csr_wdata = 0;

   odometry_scoreboard sb = new();
   bit calm = 0;          // no idling on either side
   bit hold_req = 0;
   int hold_cnt = 0;
   int cycles = 0;

   differential_drive_odometry_core u_top (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // result side: check, then pick ready for next cycle
   initial begin
      pose_item_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.x = rsp_pos_x;
            got.y = rsp_pos_y;
            got.hdg = rsp_heading;
            got.bad = rsp_bad_interval;
            sb.check_result(got);
         end
         if (hold_req) begin
            hold_req = 0;
            hold_cnt = 400;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_ready <= 0;
         end else
            rsp_ready <= calm || ($urandom_range(99) >= 35);
      end
   end

   task automatic write_csr(logic [2:0] idx, logic [17:0] d);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      sb.write_reg(idx, d);
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   task automatic send_item(logic kind, logic signed [23:0] lc, logic signed [23:0] rc,
                            logic [23:0] iv, logic [31:0] lx, logic [31:0] ly,
                            logic [31:0] lh);
      int gap;
      gap = (calm || $urandom_range(99) >= 35) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_kind <= kind;
      req_left_count <= lc;
      req_right_count <= rc;
      req_interval_us <= iv;
      req_load_x <= lx;
      req_load_y <= ly;
      req_load_heading <= lh;
      do @(posedge clock); while (!req_ready);
      sb.note_input(kind, lc, rc, iv, lx, ly, lh);
   endtask

   task automatic send_update(logic signed [23:0] lc, logic signed [23:0] rc, logic [23:0] iv);
      send_item(0, lc, rc, iv, $urandom, $urandom, $urandom);
   endtask

   task automatic send_load(logic [31:0] lx, logic [31:0] ly, logic [31:0] lh);
      send_item(1, 24'($urandom), 24'($urandom), 24'($urandom), lx, ly, lh);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending_poses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [23:0] rand_count();
      int r;
      r = $urandom_range(99);
      if (r < 50) return 24'($signed($urandom_range(4000)) - 2000);
      if (r < 65) return 24'($signed($urandom_range(200000)) - 100000);
      if (r < 75) return ($urandom_range(1)) ? 24'sh7FFFFF : 24'sh800000;
      return 24'($urandom);
   endfunction

   task automatic random_items(int count);
      logic signed [23:0] lc;
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 8)
            send_load($urandom, $urandom, $urandom);
         else if (r < 13)
            send_update(rand_count(), rand_count(), 0);
         else begin
            lc = rand_count();
            // mostly near-straight driving, some spins and arbitrary pairs
            if ($urandom_range(2) == 0) send_update(lc, rand_count(), 24'($urandom_range(1) ?
                                                    $urandom : $urandom_range(20000, 1)));
            else send_update(lc, lc + 24'($signed($urandom_range(64)) - 32),
                             24'($urandom_range(1, 16777215)));
         end
      end
   endtask

   initial begin
      sb.reset_state();
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes and special cases at reset geometry
      send_update(0, 0, 1);
      send_update(1000, 1000, 10000);
      send_update(-1000, 1000, 10000);
      send_update(24'sh7FFFFF, 24'sh7FFFFF, 24'hFFFFFF);
      send_update(24'sh800000, 24'sh800000, 1);
      send_update(24'sh800000, 24'sh7FFFFF, 5);
      send_update(24'sh7FFFFF, 24'sh800000, 5);
      send_update(500, -300, 0);                        // zero interval holds pose
      send_load(32'h7FFF_0000, 32'h8000_FFFF, 32'h4000_0000);
      send_update(24'sh7FFFFF, 24'sh7FFFFF, 100);       // wheel distances clamp
      send_load(32'h8000_0000, 32'h7FFF_FFFF, 32'h4000_0001);
      send_update(-20000, -20000, 100);
      send_load(0, 0, 32'hC000_0000);
      send_update(3000, 3000, 1);
      send_load(0, 0, 32'hBFFF_FFFF);
      send_update(3000, 3100, 1);
      send_load(0, 0, 32'h8000_0000);
      send_update(100, 100, 1);
      send_load(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
      send_update(1, 0, 24'hFFFFFF);
      drain();

      // extreme geometry, then receiver holds off while items keep coming
      write_csr(CSR_COUNTS_PER_REV, 18'd65535);
      write_csr(CSR_GEAR_RATIO, 18'd65535);
      write_csr(CSR_LEFT_RADIUS, 18'd262143);
      write_csr(CSR_RIGHT_RADIUS, 18'd262143);
      write_csr(CSR_TRACK, 18'd262143);
      hold_req = 1;
      random_items(80);
      drain();

      // minimum geometry; long stretch without idling
      write_csr(CSR_COUNTS_PER_REV, 18'd1);
      write_csr(CSR_GEAR_RATIO, 18'd1);
      write_csr(CSR_LEFT_RADIUS, 18'd1);
      write_csr(CSR_RIGHT_RADIUS, 18'd1);
      write_csr(CSR_TRACK, 18'd1);
      calm = 1;
      random_items(80);
      calm = 0;
      drain();

      // zero registers, dropped upper bits, out-of-range indexes ignored
      write_csr(CSR_COUNTS_PER_REV, 18'd0);
      write_csr(CSR_TRACK, 18'd0);
      write_csr(CSR_GEAR_RATIO, 18'h3FFFF);
      write_csr(CSR_LEFT_RADIUS, 18'd0);
      write_csr(CSR_RIGHT_RADIUS, 18'd70000);
      write_csr(3'd5, 18'($urandom));
      write_csr(3'd6, 18'($urandom));
      write_csr(3'd7, 18'($urandom));
      random_items(70);
      drain();
      write_csr(CSR_GEAR_RATIO, 18'd0);
      write_csr(CSR_LEFT_RADIUS, 18'd13107);
      random_items(20);
      drain();

      // back to defaults, pausing sender mid-run until all results are in
      write_csr(CSR_COUNTS_PER_REV, 18'(RST_COUNTS_PER_REV));
      write_csr(CSR_GEAR_RATIO, 18'(RST_GEAR_RATIO));
      write_csr(CSR_LEFT_RADIUS, RST_RADIUS);
      write_csr(CSR_RIGHT_RADIUS, RST_RADIUS);
      write_csr(CSR_TRACK, RST_TRACK);
      random_items(60);
      req_valid <= 0;
      while (sb.pending_poses.size() != 0) @(posedge clock);
      random_items(60);
      drain();

      // random geometries
      for (int p = 0; p < 3; p++) begin
         write_csr(CSR_COUNTS_PER_REV, 18'($urandom_range(65535, 1)));
         write_csr(CSR_GEAR_RATIO, 18'($urandom_range(65535, 1)));
         write_csr(CSR_LEFT_RADIUS, 18'($urandom_range(262143, 1)));
         write_csr(CSR_RIGHT_RADIUS, 18'($urandom_range(262143, 1)));
         write_csr(CSR_TRACK, 18'($urandom_range(262143, 1)));
         random_items(60);
         drain();
      end

      $display("Covered %0d updates, %0d pose loads, %0d zero-interval updates; %0d results",
               sb.n_updates, sb.n_loads, sb.n_bad, sb.checked);
      $display("Geometry swept over default, extreme, zero and random register settings");
      if (sb.mismatches == 0 && sb.pending_poses.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

### files.f
design/odo_pkg.sv
design/odo_ctrl.sv
design/odo_datapath.sv
design/differential_drive_odometry_core.sv
test/tb_differential_drive_odometry_core.sv
